FILE: rtl/brufz_pkg.sv
`timescale 1ns / 1ps

package brufz_pkg;

	// Fixed widths of the command and result words
	localparam int KIND_W   = 2;
	localparam int IDX_IN_W = 12;
	localparam int OUT_W    = 13;

	// Default geometry of the bitmap
	localparam int NBITS_DEF     = 4096;
	localparam int WORD_BITS_DEF = 32;

	// Operation codes
	localparam logic [KIND_W-1:0] KIND_SET    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_INVERT = 2'd2;

endpackage

FILE: rtl/bitmap_range_update_first_zero.sv
`timescale 1ns / 1ps
// An update walks the words of its range with a read-modify-write, then a gap
// state lets the last write-back land, then a search reads from word 0 until a
// word holds a zero; a command that changes no bit goes straight to the search.
// One command at a time; the next word is taken in the cycle done is high.
// Reset: a clearing pass writes zero to every word with busy high.
// The receiver cannot stall: done pulses for one cycle with first_zero valid.
module bitmap_range_update_first_zero
	import brufz_pkg::*;
#(
	parameter int NBITS     = NBITS_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF   // a power of two
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [KIND_W-1:0]   kind,
	input  logic [IDX_IN_W-1:0] low_index,
	input  logic [IDX_IN_W-1:0] high_index,
	output logic                done,
	output logic [OUT_W-1:0]    first_zero
);

	// Geometry: bit i sits in word i >> WBL at position i & (WORD_BITS - 1)
	localparam int NWORDS = (NBITS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int WBL    = $clog2(WORD_BITS);
	localparam int IXW    = $clog2(NBITS);
	localparam int RW     = $clog2(NBITS + 1);
	localparam int CW     = ((IDX_IN_W > IXW) ? IDX_IN_W : IXW) + 1;

	localparam logic [AW-1:0]        LAST_WORD = AW'(NWORDS - 1);
	localparam logic [WBL-1:0]       TOP_BIT   = WBL'(WORD_BITS - 1);
	localparam logic [WORD_BITS-1:0] ONES      = '1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPD,
		ST_GAP,
		ST_SRCH
	} state_t;

	state_t                state_q;
	logic [KIND_W-1:0]     kind_q;
	logic [AW-1:0]         w_first_q;
	logic [AW-1:0]         w_last_q;
	logic [WBL-1:0]        lo_bit_q;
	logic [WBL-1:0]        hi_bit_q;
	logic [AW-1:0]         addr_q;       // next word to read (or clear)
	logic                  issue_end_q;  // last read of the walk has gone out
	logic                  rd_vld_s1;
	logic [AW-1:0]         rd_addr_s1;
	logic                  done_q;
	logic [OUT_W-1:0]      first_zero_q;

	// Memory port signals
	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	logic [WORD_BITS-1:0]  mem_wdata;
	logic [WORD_BITS-1:0]  mem_rdata;

	// Command decode
	logic [CW-1:0]         lo_ext;
	logic [CW-1:0]         hi_ext;
	logic [CW-1:0]         hi_sat;
	logic                  cmd_changes;
	logic [IXW-1:0]        lo_ix;
	logic [IXW-1:0]        hi_ix;

	// Modify and search datapath
	logic [WBL-1:0]        span_lo;
	logic [WBL-1:0]        span_hi;
	logic [WORD_BITS-1:0]  span_mask;
	logic [WORD_BITS-1:0]  new_word;
	logic [WORD_BITS-1:0]  inv_word;
	logic [WORD_BITS-1:0]  low_zero;
	logic [WBL-1:0]        zero_pos;
	logic [RW-1:0]         hit_index;
	logic                  walk_last;

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign first_zero = first_zero_q;

	// Saturate the top of the range to the last bit; drop empty, off-the-end
	// and unused-code commands so that only the search runs.
	always_comb begin
		lo_ext = CW'(low_index);
		hi_ext = CW'(high_index);
		hi_sat = (hi_ext >= CW'(NBITS)) ? CW'(NBITS - 1) : hi_ext;
		cmd_changes = (kind == KIND_SET || kind == KIND_CLEAR || kind == KIND_INVERT)
			&& (lo_ext <= hi_sat) && (lo_ext < CW'(NBITS));
		lo_ix = IXW'(lo_ext);
		hi_ix = IXW'(hi_sat);
	end

	// Read-modify-write: the word read last cycle is masked over its part of
	// the range and written back in this cycle.
	always_comb begin
		span_lo   = (rd_addr_s1 == w_first_q) ? lo_bit_q : '0;
		span_hi   = (rd_addr_s1 == w_last_q) ? hi_bit_q : TOP_BIT;
		span_mask = (ONES << span_lo) & (ONES >> (TOP_BIT - span_hi));
		case (kind_q)
			KIND_SET:   new_word = mem_rdata | span_mask;
			KIND_CLEAR: new_word = mem_rdata & ~span_mask;
			default:    new_word = mem_rdata ^ span_mask;
		endcase
	end

	// Lowest zero of the word read: isolate it, then encode the one-hot bit.
	always_comb begin
		inv_word = ~mem_rdata;
		low_zero = inv_word & (~inv_word + WORD_BITS'(1));
		zero_pos = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			for (int j = 0; j < WBL; j++) begin
				if (((i >> j) & 1) == 1) begin
					zero_pos[j] = zero_pos[j] | low_zero[i];
				end
			end
		end
		hit_index = (RW'(rd_addr_s1) << WBL) | RW'(zero_pos);
	end

	// Word memory write port: zeros during the clearing pass, else write-back
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = rd_addr_s1;
		mem_wdata = new_word;
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = addr_q;
			mem_wdata = '0;
		end else if (state_q == ST_UPD && rd_vld_s1) begin
			mem_we = 1'b1;
		end
	end

	assign walk_last = (state_q == ST_UPD) ? (addr_q == w_last_q) : (addr_q == LAST_WORD);

	brufz_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (NWORDS),
		.AW    (AW)
	) u_words (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (addr_q),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			kind_q       <= '0;
			w_first_q    <= '0;
			w_last_q     <= '0;
			lo_bit_q     <= '0;
			hi_bit_q     <= '0;
			addr_q       <= '0;
			issue_end_q  <= 1'b0;
			rd_vld_s1    <= 1'b0;
			rd_addr_s1   <= '0;
			done_q       <= 1'b0;
			first_zero_q <= '0;
		end else begin
			done_q    <= 1'b0;
			rd_vld_s1 <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					// Sweep zeros through every word, one a cycle
					if (addr_q == LAST_WORD) begin
						addr_q  <= '0;
						state_q <= ST_IDLE;
					end else begin
						addr_q <= addr_q + AW'(1);
					end
				end

				ST_IDLE: begin
					if (start) begin
						kind_q      <= kind;
						lo_bit_q    <= WBL'(lo_ix);
						hi_bit_q    <= WBL'(hi_ix);
						w_first_q   <= AW'(lo_ix >> WBL);
						w_last_q    <= AW'(hi_ix >> WBL);
						issue_end_q <= 1'b0;
						if (cmd_changes) begin
							addr_q  <= AW'(lo_ix >> WBL);
							state_q <= ST_UPD;
						end else begin
							addr_q  <= '0;
							state_q <= ST_SRCH;
						end
					end
				end

				ST_UPD: begin
					// Issue one read a cycle; each write-back lands in the cycle after its read,
					// on a different word from the read then issued, so the walk needs no interlock.
					if (!issue_end_q) begin
						rd_vld_s1  <= 1'b1;
						rd_addr_s1 <= addr_q;
						if (walk_last) begin
							issue_end_q <= 1'b1;
						end else begin
							addr_q <= addr_q + AW'(1);
						end
					end
					if (rd_vld_s1 && rd_addr_s1 == w_last_q) begin
						state_q <= ST_GAP;
					end
				end

				ST_GAP: begin
					// Let the last write-back land before the search reads
					addr_q      <= '0;
					issue_end_q <= 1'b0;
					state_q     <= ST_SRCH;
				end

				ST_SRCH: begin
					if (!issue_end_q) begin
						rd_vld_s1  <= 1'b1;
						rd_addr_s1 <= addr_q;
						if (walk_last) begin
							issue_end_q <= 1'b1;
						end else begin
							addr_q <= addr_q + AW'(1);
						end
					end
					if (rd_vld_s1) begin
						if (mem_rdata != ONES) begin
							first_zero_q <= OUT_W'(hit_index);
							done_q       <= 1'b1;
							rd_vld_s1    <= 1'b0;
							addr_q       <= '0;
							state_q      <= ST_IDLE;
						end else if (rd_addr_s1 == LAST_WORD) begin
							// Every bit set: report the bitmap size
							first_zero_q <= OUT_W'(NBITS);
							done_q       <= 1'b1;
							rd_vld_s1    <= 1'b0;
							addr_q       <= '0;
							state_q      <= ST_IDLE;
						end
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/brufz_ram.sv
`timescale 1ns / 1ps

module brufz_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: bench/bitmap_range_update_first_zero_tb.sv
`timescale 1ns / 1ps

module bitmap_range_update_first_zero_tb;
	import brufz_pkg::*;

	localparam int NWORDS = NBITS_DEF / WORD_BITS_DEF;
	// Kind 3 has no package name: the block must leave the bitmap alone for it
	localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
	localparam int MAX_IDX = NBITS_DEF - 1;
	localparam int RANDOM_WORDS = 1130;
	// No sender idling over this many final words
	localparam int CALM_TAIL = 150;
	// Settle at the end for longer than the slowest command word takes
	localparam int SETTLE_CYCLES = 2 * NWORDS + 40;

	// Shadow of the bitmap: applies each accepted command word and queues the
	// lowest clear bit that the block must report for it.
	class bitmap_shadow;
		logic [WORD_BITS_DEF-1:0] words [NWORDS];
		logic [OUT_W-1:0]         first_zero_due [$];
		logic [OUT_W-1:0]         latest;
		int                       faults;

		function new();
			foreach (words[w])
				words[w] = '0;
			latest = '0;
			faults = 0;
		endfunction

		function automatic logic [OUT_W-1:0] lowest_clear_bit();
			int w;
			int b;
			for (w = 0; w < NWORDS; w++)
				if (words[w] != '1)
					for (b = 0; b < WORD_BITS_DEF; b++)
						if (!words[w][b])
							return OUT_W'(w * WORD_BITS_DEF + b);
			return OUT_W'(NBITS_DEF);
		endfunction

		function automatic void note_command(logic [KIND_W-1:0] op,
			logic [IDX_IN_W-1:0] lo, logic [IDX_IN_W-1:0] hi);
			int i;
			int top;
			// Saturate the top of the range to the last bit of the map
			top = (int'(hi) > MAX_IDX) ? MAX_IDX : int'(hi);
			if (op != KIND_NONE && int'(lo) <= top)
				for (i = int'(lo); i <= top; i++)
					case (op)
						KIND_SET:    words[i / WORD_BITS_DEF][i % WORD_BITS_DEF] = 1'b1;
						KIND_CLEAR:  words[i / WORD_BITS_DEF][i % WORD_BITS_DEF] = 1'b0;
						KIND_INVERT: words[i / WORD_BITS_DEF][i % WORD_BITS_DEF] ^= 1'b1;
						default: ;
					endcase
			latest = lowest_clear_bit();
			first_zero_due = {first_zero_due, latest};
		endfunction

		function automatic void check_result(logic [OUT_W-1:0] got);
			logic [OUT_W-1:0] want;
			if (first_zero_due.size() == 0) begin
				faults++;
				$display("%0t: unexpected result word, first_zero expected none, actual %0d",
					$time, got);
				return;
			end
			want = first_zero_due.pop_front();
			if (got !== want) begin
				faults++;
				$display("%0t: first_zero mismatch, expected %0d, actual %0d",
					$time, want, got);
			end
		endfunction

		function automatic int pending();
			return first_zero_due.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [KIND_W-1:0]   kind;
	logic [IDX_IN_W-1:0] low_index;
	logic [IDX_IN_W-1:0] high_index;
	logic                done;
	logic [OUT_W-1:0]    first_zero;

	bitmap_shadow tracker = new();

	bitmap_range_update_first_zero u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.kind       (kind),
		.low_index  (low_index),
		.high_index (high_index),
		.done       (done),
		.first_zero (first_zero)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// The result word lives for one cycle only: take it at the edge that ends it
	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			tracker.check_result(first_zero);
	end

	// Present one command word and hold it until the block takes it. The word
	// is taken at the first edge that sees start high with busy low.
	task automatic issue_command(input logic [KIND_W-1:0] op,
		input logic [IDX_IN_W-1:0] lo, input logic [IDX_IN_W-1:0] hi);
		start      <= 1'b1;
		kind       <= op;
		low_index  <= lo;
		high_index <= hi;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		tracker.note_command(op, lo, hi);
	endtask

	// Drop start for a burst of idle cycles (every caller asks for a nonzero burst, so that
	// start is never lowered and raised in the same step)
	task automatic idle_sender(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Hold off the sender until every outstanding result word has come back
	task automatic hold_until_drained();
		start <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// Clamp a signed index into the field's range
	function automatic logic [IDX_IN_W-1:0] clamp_idx(input int v);
		if (v < 0)
			return '0;
		if (v > MAX_IDX)
			return IDX_IN_W'(MAX_IDX);
		return IDX_IN_W'(v);
	endfunction

	initial begin
		int                  n;
		int                  mode;
		int                  base;
		int                  lo_i;
		bit                  quiet;
		logic [KIND_W-1:0]   op;
		logic [IDX_IN_W-1:0] lo;
		logic [IDX_IN_W-1:0] hi;

		start      <= 1'b0;
		kind       <= KIND_SET;
		low_index  <= '0;
		high_index <= '0;
		arst_n     <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: the clearing pass after reset keeps busy high, so the
		// first word simply waits for it.
		issue_command(KIND_NONE,   12'd0,    12'd4095); // unused kind on a clear map
		issue_command(KIND_SET,    12'd10,   12'd5);    // empty range
		issue_command(KIND_SET,    12'd0,    12'd0);
		issue_command(KIND_SET,    12'd0,    12'd31);   // fill the first word exactly
		issue_command(KIND_SET,    12'd32,   12'd32);   // first bit of the next word
		issue_command(KIND_SET,    12'd0,    12'd4095); // full map: no clear bit left
		issue_command(KIND_NONE,   12'd4095, 12'd0);    // unused kind on a full map
		issue_command(KIND_INVERT, 12'd4095, 12'd0);    // empty range on a full map
		issue_command(KIND_CLEAR,  12'd4095, 12'd4095); // last bit only
		issue_command(KIND_INVERT, 12'd4094, 12'd4095);
		issue_command(KIND_INVERT, 12'd0,    12'd4095);
		issue_command(KIND_SET,    12'd0,    12'd63);
		issue_command(KIND_CLEAR,  12'd33,   12'd33);
		issue_command(KIND_INVERT, 12'd31,   12'd64);   // straddle a word boundary
		idle_sender(3);
		issue_command(KIND_CLEAR,  12'd0,    12'd4095);
		issue_command(KIND_SET,    12'd1,    12'd4095);
		issue_command(KIND_INVERT, 12'd0,    12'd0);    // fills the map again
		issue_command(KIND_CLEAR,  12'd2048, 12'd2048);
		issue_command(KIND_SET,    12'd2048, 12'd2048);
		issue_command(KIND_CLEAR,  12'd1365, 12'd2730); // alternating bit patterns
		issue_command(KIND_INVERT, 12'd2730, 12'd1365);
		issue_command(KIND_CLEAR,  12'd0,    12'd4095);
		hold_until_drained();

		// Random part. Half the words grow or reshape the run of ones at the bottom
		// of the map, so the search is pushed deep; the rest is plain noise.
		quiet = 1'b0;
		for (n = 0; n < RANDOM_WORDS; n++) begin
			mode = $urandom_range(0, 19);
			if (mode < 5) begin
				// extend a prefix of ones
				op   = KIND_SET;
				lo_i = $urandom_range(0, 40);
				lo   = IDX_IN_W'(lo_i);
				hi   = clamp_idx($urandom_range(lo_i, MAX_IDX));
			end else if (mode < 10) begin
				// short hole or patch anywhere
				op   = KIND_W'($urandom_range(0, 2));
				lo_i = $urandom_range(0, MAX_IDX);
				lo   = IDX_IN_W'(lo_i);
				hi   = clamp_idx(lo_i + $urandom_range(0, 70));
			end else if (mode < 15) begin
				// work right around the current lowest clear bit
				op   = KIND_W'($urandom_range(0, 2));
				base = int'(tracker.latest);
				if (base > MAX_IDX)
					base = $urandom_range(0, MAX_IDX);
				lo = clamp_idx(base - $urandom_range(0, 3));
				hi = clamp_idx(base + $urandom_range(0, 40));
			end else if (mode < 19) begin
				// noise: unused kind and reversed ranges included
				op = KIND_W'($urandom_range(0, 3));
				lo = IDX_IN_W'($urandom_range(0, MAX_IDX));
				hi = IDX_IN_W'($urandom_range(0, MAX_IDX));
			end else begin
				// whole-map sweep
				op = ($urandom_range(0, 1) == 0) ? KIND_SET : KIND_CLEAR;
				lo = '0;
				hi = IDX_IN_W'(MAX_IDX);
			end
			issue_command(op, lo, hi);

			// Alternate stretches with and without sender gaps
			if (n % 64 == 0)
				quiet = ($urandom_range(0, 2) == 0);
			if (n == RANDOM_WORDS / 2)
				hold_until_drained();
			else if (!quiet && n < RANDOM_WORDS - CALM_TAIL && $urandom_range(0, 2) == 0)
				idle_sender($urandom_range(1, 8));
		end

		// Drain, then give any stray result word time to show up
		start <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (tracker.faults == 0 && tracker.pending() == 0)
			$display("bitmap_range_update_first_zero_tb: clean");
		else
			$display("bitmap_range_update_first_zero_tb: errors");
		$finish;
	end

	// Watchdog: several times the slowest legal run
	initial begin
		#5_000_000;
		$display("bitmap_range_update_first_zero_tb: errors");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/brufz_pkg.sv
rtl/brufz_ram.sv
rtl/bitmap_range_update_first_zero.sv
bench/bitmap_range_update_first_zero_tb.sv
